/* sv/u8c_pkg.sv */
// u8c_pkg: shared types, constants and code page tables for the UTF-8 / cp1252 transcoder.
// No dependencies; imported by u8c_step and utf8_cp1252_transcoder_core.
package u8c_pkg;

    localparam logic [7:0]  QMARK    = 8'h3F;
    localparam logic [15:0] REPL_CP  = 16'hFFFD;
    localparam logic [20:0] CP_MAX   = 21'h10FFFF;
    localparam logic [20:0] SURR_LO  = 21'h00D800;
    localparam logic [20:0] SURR_HI  = 21'h00DFFF;

    // four-entry byte window, entry 0 is the oldest byte
    typedef logic [3:0][7:0] t_buf;

    // one decode/encode step
    typedef struct packed {
        logic       stop;     // incomplete sequence, keep bytes pending
        logic [7:0] obyte;
        logic       bad;
        logic       unm;
        logic [2:0] adv;      // bytes consumed from the window
        logic       more;     // encoder: another byte follows
    } t_step;

    // cp1252 0x80..0x9F to code point, 0 for unassigned slots
    function automatic logic [15:0] high_cp(input logic [4:0] slot);
        logic [15:0] cp;
        unique case (slot)
            5'd0:    cp = 16'h20AC;
            5'd2:    cp = 16'h201A;
            5'd3:    cp = 16'h0192;
            5'd4:    cp = 16'h201E;
            5'd5:    cp = 16'h2026;
            5'd6:    cp = 16'h2020;
            5'd7:    cp = 16'h2021;
            5'd8:    cp = 16'h02C6;
            5'd9:    cp = 16'h2030;
            5'd10:   cp = 16'h0160;
            5'd11:   cp = 16'h2039;
            5'd12:   cp = 16'h0152;
            5'd14:   cp = 16'h017D;
            5'd17:   cp = 16'h2018;
            5'd18:   cp = 16'h2019;
            5'd19:   cp = 16'h201C;
            5'd20:   cp = 16'h201D;
            5'd21:   cp = 16'h2022;
            5'd22:   cp = 16'h2013;
            5'd23:   cp = 16'h2014;
            5'd24:   cp = 16'h02DC;
            5'd25:   cp = 16'h2122;
            5'd26:   cp = 16'h0161;
            5'd27:   cp = 16'h203A;
            5'd28:   cp = 16'h0153;
            5'd30:   cp = 16'h017E;
            5'd31:   cp = 16'h0178;
            default: cp = 16'h0000;
        endcase
        return cp;
    endfunction

    // reverse lookup: {hit, slot}
    function automatic logic [5:0] slot_of(input logic [20:0] cp);
        logic [5:0] r;
        unique case (cp)
            21'h020AC: r = {1'b1, 5'd0};
            21'h0201A: r = {1'b1, 5'd2};
            21'h00192: r = {1'b1, 5'd3};
            21'h0201E: r = {1'b1, 5'd4};
            21'h02026: r = {1'b1, 5'd5};
            21'h02020: r = {1'b1, 5'd6};
            21'h02021: r = {1'b1, 5'd7};
            21'h002C6: r = {1'b1, 5'd8};
            21'h02030: r = {1'b1, 5'd9};
            21'h00160: r = {1'b1, 5'd10};
            21'h02039: r = {1'b1, 5'd11};
            21'h00152: r = {1'b1, 5'd12};
            21'h0017D: r = {1'b1, 5'd14};
            21'h02018: r = {1'b1, 5'd17};
            21'h02019: r = {1'b1, 5'd18};
            21'h0201C: r = {1'b1, 5'd19};
            21'h0201D: r = {1'b1, 5'd20};
            21'h02022: r = {1'b1, 5'd21};
            21'h02013: r = {1'b1, 5'd22};
            21'h02014: r = {1'b1, 5'd23};
            21'h002DC: r = {1'b1, 5'd24};
            21'h02122: r = {1'b1, 5'd25};
            21'h00161: r = {1'b1, 5'd26};
            21'h0203A: r = {1'b1, 5'd27};
            21'h00153: r = {1'b1, 5'd28};
            21'h0017E: r = {1'b1, 5'd30};
            21'h00178: r = {1'b1, 5'd31};
            default:   r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

/* sv/u8c_in_if.sv */
// u8c_in_if: input word channel (valid/ready) of the transcoder.
// No dependencies.
interface u8c_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

/* sv/u8c_out_if.sv */
// u8c_out_if: result word channel (valid/ready) of the transcoder.
// No dependencies.
interface u8c_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       bad_sequence;
    logic       unmapped;
    logic       last_of_run;

    modport source (output valid, output out_byte, output bad_sequence,
                    output unmapped, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input bad_sequence,
                    input unmapped, input last_of_run, output ready);
endinterface

/* sv/u8c_step.sv */
// u8c_step: shared decode/encode unit; one result byte per invocation.
// Depends on u8c_pkg.
module u8c_step
    import u8c_pkg::*;
(
    input  logic       i_dir,
    input  t_buf       i_buf,
    input  logic [2:0] i_cnt,
    input  logic       i_eot,
    input  logic [7:0] i_in_byte,
    input  logic [1:0] i_idx,
    output t_step      o_step
);

    always_comb begin
        logic [7:0]  lead;
        logic [1:0]  extra;
        logic        lead_ok;
        logic [2:0]  avail;
        logic [2:0]  have;
        logic [3:1]  cont;
        logic        pref_ok;
        logic        short_seq;
        logic [20:0] cp;
        logic        overlong;
        logic        seq_bad;
        logic [5:0]  hit;
        logic [15:0] enc_cp;
        logic [15:0] tcp;
        logic [1:0]  nbytes;

        o_step  = '0;
        lead    = i_buf[0];
        extra   = 2'd0;
        lead_ok = 1'b1;
        cp      = '0;
        hit     = '0;
        enc_cp  = '0;
        tcp     = '0;
        nbytes  = 2'd1;

        if (lead[7:5] == 3'b110) begin
            extra = 2'd1;
        end else if (lead[7:4] == 4'b1110) begin
            extra = 2'd2;
        end else if (lead[7:3] == 5'b11110) begin
            extra = 2'd3;
        end else begin
            lead_ok = 1'b0;
        end

        avail     = i_cnt - 3'd1;
        have      = (avail < {1'b0, extra}) ? avail : {1'b0, extra};
        short_seq = avail < {1'b0, extra};
        cont[1]   = i_buf[1][7:6] == 2'b10;
        cont[2]   = i_buf[2][7:6] == 2'b10;
        cont[3]   = i_buf[3][7:6] == 2'b10;
        pref_ok   = !((have >= 3'd1 && !cont[1]) || (have >= 3'd2 && !cont[2]) ||
                      (have >= 3'd3 && !cont[3]));

        case (extra)
            2'd1:    cp = {10'd0, lead[4:0], i_buf[1][5:0]};
            2'd2:    cp = {5'd0, lead[3:0], i_buf[1][5:0], i_buf[2][5:0]};
            2'd3:    cp = {lead[2:0], i_buf[1][5:0], i_buf[2][5:0], i_buf[3][5:0]};
            default: cp = '0;
        endcase

        overlong = (extra == 2'd1 && cp < 21'h80) || (extra == 2'd2 && cp < 21'h800) ||
                   (extra == 2'd3 && cp < 21'h10000);
        seq_bad  = !pref_ok || (short_seq && i_eot) ||
                   (!short_seq && (overlong || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)));

        if (!i_dir) begin
            o_step.adv = 3'd1;
            if (!lead[7]) begin
                o_step.obyte = lead;
            end else if (!lead_ok) begin
                o_step.obyte = QMARK;
                o_step.bad   = 1'b1;
            end else if (pref_ok && short_seq && !i_eot) begin
                o_step.stop = 1'b1;
            end else if (seq_bad) begin
                o_step.obyte = QMARK;
                o_step.bad   = 1'b1;
            end else begin
                o_step.adv = {1'b0, extra} + 3'd1;
                if (cp < 21'h80 || (cp >= 21'hA0 && cp <= 21'hFF)) begin
                    o_step.obyte = cp[7:0];
                end else begin
                    hit = slot_of(cp);
                    if (hit[5]) begin
                        o_step.obyte = {3'b100, hit[4:0]};
                    end else begin
                        o_step.obyte = QMARK;
                        o_step.unm   = 1'b1;
                    end
                end
            end
        end else begin
            // cp1252 byte to UTF-8, byte i_idx of the encoding
            if (!i_in_byte[7] || i_in_byte >= 8'hA0) begin
                enc_cp = {8'd0, i_in_byte};
            end else begin
                tcp    = high_cp(i_in_byte[4:0]);
                enc_cp = (tcp != 16'h0000) ? tcp : REPL_CP;
            end
            if (enc_cp < 16'h0080) begin
                nbytes = 2'd1;
            end else if (enc_cp < 16'h0800) begin
                nbytes = 2'd2;
            end else begin
                nbytes = 2'd3;
            end
            case (nbytes)
                2'd1:    o_step.obyte = enc_cp[7:0];
                2'd2:    o_step.obyte = (i_idx == 2'd0) ? {3'b110, enc_cp[10:6]}
                                                         : {2'b10, enc_cp[5:0]};
                default: begin
                    case (i_idx)
                        2'd0:    o_step.obyte = {4'b1110, enc_cp[15:12]};
                        2'd1:    o_step.obyte = {2'b10, enc_cp[11:6]};
                        default: o_step.obyte = {2'b10, enc_cp[5:0]};
                    endcase
                end
            endcase
            o_step.more = (i_idx + 2'd1) < nbytes;
        end
    end

endmodule

/* sv/utf8_cp1252_transcoder_core.sv */
// utf8_cp1252_transcoder_core: top level, step sequencer, pending byte window, output register.
// Depends on u8c_pkg, u8c_in_if, u8c_out_if and u8c_step.
//
//  channel   dir  handshake     payload
//  i_in      in   valid/ready   in_byte[7:0], end_of_text
//  o_out     out  valid/ready   out_byte[7:0], bad_sequence, unmapped, last_of_run
//  i_cfg_*   in   we only       wdata = direction
//
// An input word causes N result words (0..4). It is accepted, each result is produced by the
// step unit in turn, and a closing step flushes the last one; results wait on a stalled output.
// Each result passes a hold register so last_of_run is known before it is presented.
// i_rst_n (sync, active low) clears the sequencer, the pending count and direction.
// A stalled output freezes the sequencer while a word is held; i_in.ready is high only in idle.
module utf8_cp1252_transcoder_core
    import u8c_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    u8c_in_if.sink      i_in,
    u8c_out_if.source   o_out
);

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state     r_state, n_state;
    logic       r_dir, n_dir;
    t_buf       r_buf, n_buf;
    logic [2:0] r_cnt, n_cnt;
    logic       r_eot, n_eot;
    logic [7:0] r_in, n_in;
    logic [1:0] r_idx, n_idx;
    logic       r_enc_done, n_enc_done;
    logic       r_hold_v, n_hold_v;
    logic [7:0] r_hold_byte, n_hold_byte;
    logic       r_hold_bad, n_hold_bad;
    logic       r_hold_unm, n_hold_unm;
    logic       r_out_v, n_out_v;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_bad, n_out_bad;
    logic       r_out_unm, n_out_unm;
    logic       r_out_last, n_out_last;

    t_step      step;
    logic       accept;
    logic       out_free;
    logic       fin;

    u8c_step u_step (
        .i_dir     (r_dir),
        .i_buf     (r_buf),
        .i_cnt     (r_cnt),
        .i_eot     (r_eot),
        .i_in_byte (r_in),
        .i_idx     (r_idx),
        .o_step    (step)
    );

    assign i_in.ready         = (r_state == ST_IDLE);
    assign accept             = i_in.valid && i_in.ready;
    assign out_free           = !r_out_v || o_out.ready;
    assign fin                = r_dir ? r_enc_done : (r_cnt == 3'd0 || step.stop);

    assign o_out.valid        = r_out_v;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.bad_sequence = r_out_bad;
    assign o_out.unmapped     = r_out_unm;
    assign o_out.last_of_run  = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_dir       = i_cfg_we ? i_cfg_wdata : r_dir;
        n_buf       = r_buf;
        n_cnt       = r_cnt;
        n_eot       = r_eot;
        n_in        = r_in;
        n_idx       = r_idx;
        n_enc_done  = r_enc_done;
        n_hold_v    = r_hold_v;
        n_hold_byte = r_hold_byte;
        n_hold_bad  = r_hold_bad;
        n_hold_unm  = r_hold_unm;
        n_out_v     = r_out_v && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_bad   = r_out_bad;
        n_out_unm   = r_out_unm;
        n_out_last  = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state    = ST_RUN;
                    n_in       = i_in.in_byte;
                    n_eot      = i_in.end_of_text;
                    n_idx      = 2'd0;
                    n_enc_done = 1'b0;
                    if (!r_dir) begin
                        n_buf[r_cnt[1:0]] = i_in.in_byte;
                        n_cnt             = r_cnt + 3'd1;
                    end
                end
            end
            ST_RUN: begin
                if (fin) begin
                    // flush the held word as the last one of this input
                    if (!r_hold_v) begin
                        n_state = ST_IDLE;
                    end else if (out_free) begin
                        n_out_v    = 1'b1;
                        n_out_byte = r_hold_byte;
                        n_out_bad  = r_hold_bad;
                        n_out_unm  = r_hold_unm;
                        n_out_last = 1'b1;
                        n_hold_v   = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end else if (!r_hold_v || out_free) begin
                    if (r_hold_v) begin
                        n_out_v    = 1'b1;
                        n_out_byte = r_hold_byte;
                        n_out_bad  = r_hold_bad;
                        n_out_unm  = r_hold_unm;
                        n_out_last = 1'b0;
                    end
                    n_hold_v    = 1'b1;
                    n_hold_byte = step.obyte;
                    n_hold_bad  = step.bad;
                    n_hold_unm  = step.unm;
                    if (r_dir) begin
                        n_idx      = r_idx + 2'd1;
                        n_enc_done = !step.more;
                    end else begin
                        n_buf = t_buf'(r_buf >> {step.adv, 3'b000});
                        n_cnt = r_cnt - step.adv;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_dir      <= 1'b0;
            r_cnt      <= 3'd0;
            r_idx      <= 2'd0;
            r_enc_done <= 1'b0;
            r_hold_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_dir      <= n_dir;
            r_cnt      <= n_cnt;
            r_idx      <= n_idx;
            r_enc_done <= n_enc_done;
            r_hold_v   <= n_hold_v;
            r_out_v    <= n_out_v;
        end
        r_buf       <= n_buf;
        r_eot       <= n_eot;
        r_in        <= n_in;
        r_hold_byte <= n_hold_byte;
        r_hold_bad  <= n_hold_bad;
        r_hold_unm  <= n_hold_unm;
        r_out_byte  <= n_out_byte;
        r_out_bad   <= n_out_bad;
        r_out_unm   <= n_out_unm;
        r_out_last  <= n_out_last;
    end

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_hold_v)
        else $error("held word left over in idle");

    a_pending_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_cnt <= 3'd3))
        else $error("more than three pending bytes");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready)
        else $error("ready right after accept");

    a_flag_is_qmark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out_bad || r_out_unm)) |-> (r_out_byte == QMARK))
        else $error("flagged word is not a question mark");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> !(r_out_bad && r_out_unm))
        else $error("bad_sequence and unmapped both set");

endmodule
